// ===== hw/rtl/smc_pkg.sv =====
// Shared types, codes and decode tables for the stack machine core.
// Used by every module of the core but smc_div; depends on nothing.
`default_nettype none

package smc_pkg;

  localparam int MEM_DEPTH   = 65536;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int STACK_DEPTH = 256;
  localparam int DEV_DEPTH   = 256;

  // Machine status codes.
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_DIVZ  = 3'd4;

  // Item operations.
  localparam logic [1:0] IOP_MEM   = 2'd0;
  localparam logic [1:0] IOP_DEV   = 2'd1;
  localparam logic [1:0] IOP_START = 2'd2;
  localparam logic [1:0] IOP_EXEC  = 2'd3;

  // Instruction byte fields.
  localparam logic [7:0] OPC_MASK = 8'h1F;
  localparam int         BIT_SHORT = 5;
  localparam int         BIT_RET   = 6;
  localparam int         BIT_KEEP  = 7;

  // Opcodes (low five bits of the instruction byte).
  localparam logic [4:0] OP_LIT = 5'h00;
  localparam logic [4:0] OP_INC = 5'h01;
  localparam logic [4:0] OP_POP = 5'h02;
  localparam logic [4:0] OP_NIP = 5'h03;
  localparam logic [4:0] OP_SWP = 5'h04;
  localparam logic [4:0] OP_ROT = 5'h05;
  localparam logic [4:0] OP_DUP = 5'h06;
  localparam logic [4:0] OP_OVR = 5'h07;
  localparam logic [4:0] OP_EQU = 5'h08;
  localparam logic [4:0] OP_NEQ = 5'h09;
  localparam logic [4:0] OP_GTH = 5'h0A;
  localparam logic [4:0] OP_LTH = 5'h0B;
  localparam logic [4:0] OP_JMP = 5'h0C;
  localparam logic [4:0] OP_JCN = 5'h0D;
  localparam logic [4:0] OP_JSR = 5'h0E;
  localparam logic [4:0] OP_STH = 5'h0F;
  localparam logic [4:0] OP_LDZ = 5'h10;
  localparam logic [4:0] OP_STZ = 5'h11;
  localparam logic [4:0] OP_LDR = 5'h12;
  localparam logic [4:0] OP_STR = 5'h13;
  localparam logic [4:0] OP_LDA = 5'h14;
  localparam logic [4:0] OP_STA = 5'h15;
  localparam logic [4:0] OP_DEI = 5'h16;
  localparam logic [4:0] OP_DEO = 5'h17;
  localparam logic [4:0] OP_ADD = 5'h18;
  localparam logic [4:0] OP_SUB = 5'h19;
  localparam logic [4:0] OP_MUL = 5'h1A;
  localparam logic [4:0] OP_DIV = 5'h1B;
  localparam logic [4:0] OP_AND = 5'h1C;
  localparam logic [4:0] OP_ORA = 5'h1D;
  localparam logic [4:0] OP_EOR = 5'h1E;
  localparam logic [4:0] OP_SFT = 5'h1F;

  // Stack capacity limits for one-byte and two-byte pushes.
  localparam logic [7:0] PUSH_LIMIT1 = 8'd254;
  localparam logic [7:0] PUSH_LIMIT2 = 8'd253;

  // System ports that alias the stack pointers.
  localparam logic [7:0] PORT_DSP = 8'h02;
  localparam logic [7:0] PORT_RSP = 8'h03;

  // Push value sources.
  localparam logic [2:0] SRC_R0  = 3'd0;
  localparam logic [2:0] SRC_R1  = 3'd1;
  localparam logic [2:0] SRC_R2  = 3'd2;
  localparam logic [2:0] SRC_RES = 3'd3;
  localparam logic [2:0] SRC_PC  = 3'd4;

  // Read capture modes for the result register.
  localparam logic [1:0] CAP_NONE = 2'd0;
  localparam logic [1:0] CAP_BYTE = 2'd1;
  localparam logic [1:0] CAP_HI   = 2'd2;
  localparam logic [1:0] CAP_LO   = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] program_counter;
    logic        port_write_valid;
    logic [7:0]  port_number;
    logic [15:0] port_value;
    logic        port_wide;
  } result_t;

  typedef struct packed {
    logic       latch_in;
    logic       host_wr;
    logic       clr_step;
    logic       decode;
    logic       halt;
    logic       prep;
    logic       pop_rd;
    logic       pop_cap_lo;
    logic       pop_cap_hi;
    logic       pop_commit;
    logic [1:0] slot;
    logic       fault;
    logic [2:0] fault_code;
    logic       alu;
    logic       div_start;
    logic       div_take;
    logic       jump;
    logic       ea_load;
    logic       rd_pc;
    logic       rd_dev;
    logic       second;
    logic [1:0] cap;
    logic       mem_wr;
    logic       dev_wr;
    logic       wr_hi;
    logic       report;
    logic       push_wr;
    logic [2:0] push_src;
    logic       push_hi;
    logic       push_other;
    logic       lit_push;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ir;
    logic [7:0] k;
    logic [7:0] dsp;
    logic [7:0] rsp;
    logic       r0_zero;
    logic       r1_flag;
    logic       div_done;
    logic       clear_last;
    logic [1:0] item_op;
    logic       running;
    logic       out_free;
  } sts_t;

  function automatic logic [1:0] pop_count(input logic [4:0] o);
    logic [1:0] n;
    case (o) inside
      OP_LIT: n = 2'd0;
      OP_INC, OP_POP, OP_DUP, OP_JMP, OP_JSR, OP_STH,
      OP_LDZ, OP_LDR, OP_LDA, OP_DEI: n = 2'd1;
      OP_ROT: n = 2'd3;
      default: n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic logic pop_wide(input logic [4:0] o, input logic [1:0] i,
                                    input logic wide);
    logic w;
    w = wide;
    if (i == 2'd0) begin
      case (o) inside
        OP_LDZ, OP_STZ, OP_LDR, OP_STR, OP_DEI, OP_DEO, OP_SFT: w = 1'b0;
        OP_LDA, OP_STA: w = 1'b1;
        default: w = wide;
      endcase
    end else if (i == 2'd1 && o == OP_JCN) begin
      w = 1'b0;
    end
    return w;
  endfunction

  function automatic logic [1:0] push_count(input logic [4:0] o);
    logic [1:0] n;
    case (o) inside
      OP_POP, OP_JMP, OP_JCN, OP_STZ, OP_STR, OP_STA, OP_DEO, OP_LIT: n = 2'd0;
      OP_SWP, OP_DUP: n = 2'd2;
      OP_ROT, OP_OVR: n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] push_src(input logic [4:0] o, input logic [1:0] j);
    logic [2:0] s;
    case (o) inside
      OP_NIP, OP_DUP, OP_STH: s = SRC_R0;
      OP_SWP: s = (j == 2'd0) ? SRC_R0 : SRC_R1;
      OP_ROT: s = (j == 2'd0) ? SRC_R1 : ((j == 2'd1) ? SRC_R0 : SRC_R2);
      OP_OVR: s = (j == 2'd1) ? SRC_R0 : SRC_R1;
      OP_JSR: s = SRC_PC;
      default: s = SRC_RES;
    endcase
    return s;
  endfunction

  function automatic logic push_wide(input logic [4:0] o, input logic wide);
    logic w;
    case (o) inside
      OP_EQU, OP_NEQ, OP_GTH, OP_LTH: w = 1'b0;
      OP_JSR: w = 1'b1;
      default: w = wide;
    endcase
    return w;
  endfunction

  function automatic logic push_other(input logic [4:0] o);
    return (o == OP_JSR) || (o == OP_STH);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smc_div.sv =====
// Sixteen-bit restoring divider, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none

module smc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] shifted;
  logic        fits;

  assign shifted = {rem, quotient[15]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? 16'(shifted - {1'b0, dvs}) : shifted[15:0];
      quotient <= {quotient[14:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/smc_datapath.sv =====
// Datapath of the stack machine core: memories, stacks, registers, ALU, result register.
// Depends on smc_pkg and smc_div; driven by the command struct from smc_ctrl.
`default_nettype none

module smc_datapath
  import smc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cmd_t    cmd,
  input  wire item_t   item,
  input  wire logic    result_stall,
  output sts_t         sts,
  output logic         result_valid,
  output result_t      result
);

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  dev [DEV_DEPTH];
  logic [7:0]  dstk [STACK_DEPTH];
  logic [7:0]  rstk [STACK_DEPTH];

  logic [15:0] pc;
  logic [2:0]  status;
  logic [7:0]  dsp;
  logic [7:0]  rsp;
  logic [7:0]  ir;
  logic [7:0]  k;
  logic [15:0] r0;
  logic [15:0] r1;
  logic [15:0] r2;
  logic [15:0] res;
  logic [15:0] ea;
  logic [1:0]  in_op;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic [MEM_AW-1:0] clr_cnt;
  logic        pw_valid;
  logic [7:0]  pw_num;
  logic [15:0] pw_val;
  logic        pw_wide;

  logic [7:0]  mem_rdata;
  logic [7:0]  dev_rdata;
  logic [7:0]  dev_rport;
  logic [7:0]  ds_rdata;
  logic [7:0]  rs_rdata;

  logic [4:0]  op5;
  logic        wide;
  logic        ret;
  logic        keep;
  logic [15:0] rel_pc;
  logic [15:0] jump_pc;
  logic [15:0] ea_plus;
  logic [7:0]  port;
  logic [7:0]  wr_byte;
  logic [7:0]  dev_byte;
  logic [7:0]  cap_byte;
  logic [7:0]  stk_byte;
  logic [15:0] alu_val;
  logic [15:0] src_val;
  logic        tgt_rs;
  logic [7:0]  tgt_p;
  logic [15:0] quot;
  logic        div_done;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic [MEM_AW-1:0] mem_ra;
  logic              dev_we;
  logic [7:0]        dev_wa;
  logic [7:0]        dev_wd;
  logic              stk_we;

  assign op5  = ir[4:0];
  assign wide = ir[BIT_SHORT];
  assign ret  = ir[BIT_RET];
  assign keep = ir[BIT_KEEP];

  assign rel_pc  = pc + {{8{r0[7]}}, r0[7:0]};
  assign jump_pc = wide ? r0 : rel_pc;
  assign ea_plus = ea + 16'd1;
  assign port    = cmd.second ? {r0[7:4], r0[3:0] + 4'd1} : r0[7:0];
  assign wr_byte = cmd.wr_hi ? r1[15:8] : r1[7:0];

  // Stack pointer aliases override the page on reads of the system ports.
  assign dev_byte = (dev_rport == PORT_DSP) ? dsp :
                    ((dev_rport == PORT_RSP) ? rsp : dev_rdata);
  assign cap_byte = cmd.rd_dev ? dev_byte : mem_rdata;

  always_comb begin
    case (op5) inside
      OP_INC:  alu_val = r0 + 16'd1;
      OP_EQU:  alu_val = {15'd0, r1 == r0};
      OP_NEQ:  alu_val = {15'd0, r1 != r0};
      OP_GTH:  alu_val = {15'd0, r1 > r0};
      OP_LTH:  alu_val = {15'd0, r1 < r0};
      OP_ADD:  alu_val = r1 + r0;
      OP_SUB:  alu_val = r1 - r0;
      OP_MUL:  alu_val = 16'(r1 * r0);
      OP_AND:  alu_val = r1 & r0;
      OP_ORA:  alu_val = r1 | r0;
      OP_EOR:  alu_val = r1 ^ r0;
      OP_SFT:  alu_val = (r1 >> r0[3:0]) << r0[7:4];
      default: alu_val = r0;
    endcase
  end

  always_comb begin
    case (cmd.push_src)
      SRC_R0:  src_val = r0;
      SRC_R1:  src_val = r1;
      SRC_R2:  src_val = r2;
      SRC_PC:  src_val = pc;
      default: src_val = res;
    endcase
  end

  assign tgt_rs   = ret ^ cmd.push_other;
  assign tgt_p    = tgt_rs ? rsp : dsp;
  assign stk_we   = cmd.push_wr || cmd.lit_push;
  assign stk_byte = cmd.lit_push ? mem_rdata :
                    (cmd.push_hi ? src_val[15:8] : src_val[7:0]);

  // Main memory port muxing.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ea[MEM_AW-1:0];
    mem_wd = wr_byte;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = 8'd0;
    end else if (cmd.host_wr && in_op == IOP_MEM) begin
      mem_we = 1'b1;
      mem_wa = in_addr[MEM_AW-1:0];
      mem_wd = in_data;
    end else if (cmd.mem_wr) begin
      mem_we = 1'b1;
      mem_wa = cmd.second ? ea_plus[MEM_AW-1:0] : ea[MEM_AW-1:0];
    end
    if (cmd.rd_pc) begin
      mem_ra = pc[MEM_AW-1:0];
    end else begin
      mem_ra = cmd.second ? ea_plus[MEM_AW-1:0] : ea[MEM_AW-1:0];
    end
  end

  always_comb begin
    dev_we = 1'b0;
    dev_wa = port;
    dev_wd = wr_byte;
    if (cmd.clr_step) begin
      dev_we = 1'b1;
      dev_wa = clr_cnt[7:0];
      dev_wd = 8'd0;
    end else if (cmd.host_wr && in_op == IOP_DEV) begin
      dev_we = 1'b1;
      dev_wa = in_addr[7:0];
      dev_wd = in_data;
    end else if (cmd.dev_wr) begin
      dev_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (dev_we) begin
      dev[dev_wa] <= dev_wd;
    end
    dev_rdata <= dev[port];
    dev_rport <= port;
  end

  always_ff @(posedge clk) begin
    if (stk_we && !tgt_rs) begin
      dstk[tgt_p] <= stk_byte;
    end
    ds_rdata <= dstk[k - 8'd1];
  end

  always_ff @(posedge clk) begin
    if (stk_we && tgt_rs) begin
      rstk[tgt_p] <= stk_byte;
    end
    rs_rdata <= rstk[k - 8'd1];
  end

  smc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (r1),
    .divisor  (r0),
    .done     (div_done),
    .quotient (quot)
  );

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      status  <= ST_HALT;
      dsp     <= '0;
      rsp     <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + MEM_AW'(1);
      end
      if (cmd.host_wr && in_op == IOP_START) begin
        pc     <= in_addr;
        status <= (in_addr == 16'd0) ? ST_HALT : ST_RUN;
      end
      if (cmd.decode || cmd.lit_push) begin
        pc <= pc + 16'd1;
      end
      if (cmd.jump) begin
        pc <= jump_pc;
      end
      if (cmd.halt) begin
        status <= ST_HALT;
      end
      if (cmd.fault) begin
        status <= cmd.fault_code;
      end
      if (cmd.pop_commit && !keep) begin
        if (ret) begin
          rsp <= k;
        end else begin
          dsp <= k;
        end
      end
      if (stk_we) begin
        if (tgt_rs) begin
          rsp <= rsp + 8'd1;
        end else begin
          dsp <= dsp + 8'd1;
        end
      end
      if (cmd.dev_wr && port == PORT_DSP) begin
        dsp <= wr_byte;
      end
      if (cmd.dev_wr && port == PORT_RSP) begin
        rsp <= wr_byte;
      end
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_op   <= item.operation;
      in_addr <= item.address;
      in_data <= item.data;
    end
    if (cmd.decode) begin
      ir <= mem_rdata;
    end
    if (cmd.prep) begin
      k <= ret ? rsp : dsp;
    end
    if (cmd.pop_rd) begin
      k <= k - 8'd1;
    end
    if (cmd.pop_cap_lo || cmd.pop_cap_hi) begin
      case (cmd.slot)
        2'd0: r0 <= cmd.pop_cap_hi ? {(ret ? rs_rdata : ds_rdata), r0[7:0]}
                                   : {8'd0, (ret ? rs_rdata : ds_rdata)};
        2'd1: r1 <= cmd.pop_cap_hi ? {(ret ? rs_rdata : ds_rdata), r1[7:0]}
                                   : {8'd0, (ret ? rs_rdata : ds_rdata)};
        default: r2 <= cmd.pop_cap_hi ? {(ret ? rs_rdata : ds_rdata), r2[7:0]}
                                      : {8'd0, (ret ? rs_rdata : ds_rdata)};
      endcase
    end
    if (cmd.alu) begin
      res <= alu_val;
    end
    if (cmd.div_take) begin
      res <= quot;
    end
    case (cmd.cap)
      CAP_BYTE: res <= {8'd0, cap_byte};
      CAP_HI:   res[15:8] <= cap_byte;
      CAP_LO:   res[7:0] <= cap_byte;
      default: ;
    endcase
    if (cmd.ea_load) begin
      case (op5) inside
        OP_LDZ, OP_STZ: ea <= {8'd0, r0[7:0]};
        OP_LDR, OP_STR: ea <= rel_pc;
        default:        ea <= r0;
      endcase
    end
  end

  // Device output report of the current item.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      pw_valid <= 1'b0;
      pw_num   <= '0;
      pw_val   <= '0;
      pw_wide  <= 1'b0;
    end else if (cmd.report) begin
      pw_valid <= 1'b1;
      pw_num   <= r0[7:0];
      pw_val   <= wide ? r1 : {8'd0, r1[7:0]};
      pw_wide  <= wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.status           <= status;
      result.program_counter  <= pc;
      result.port_write_valid <= pw_valid;
      result.port_number      <= pw_num;
      result.port_value       <= pw_val;
      result.port_wide        <= pw_wide;
    end
  end

  assign sts.ir         = ir;
  assign sts.k          = k;
  assign sts.dsp        = dsp;
  assign sts.rsp        = rsp;
  assign sts.r0_zero    = (r0 == 16'd0);
  assign sts.r1_flag    = (r1[7:0] != 8'd0);
  assign sts.div_done   = div_done;
  assign sts.clear_last = (clr_cnt == MEM_AW'(MEM_DEPTH - 1));
  assign sts.item_op    = in_op;
  assign sts.running    = (status == ST_RUN);
  assign sts.out_free   = !result_valid || !result_stall;

endmodule

`default_nettype wire

// ===== hw/rtl/smc_ctrl.sv =====
// Controller state machine of the stack machine core.
// Depends on smc_pkg; issues the command struct to smc_datapath and reads its status.
`default_nettype none

module smc_ctrl
  import smc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      ready
);

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_FETCH   = 5'd3;
  localparam logic [4:0] S_DECODE  = 5'd4;
  localparam logic [4:0] S_PREP    = 5'd5;
  localparam logic [4:0] S_LIT     = 5'd6;
  localparam logic [4:0] S_LIT_P   = 5'd7;
  localparam logic [4:0] S_POP     = 5'd8;
  localparam logic [4:0] S_POP_B0  = 5'd9;
  localparam logic [4:0] S_POP_B1  = 5'd10;
  localparam logic [4:0] S_POP_END = 5'd11;
  localparam logic [4:0] S_EXEC    = 5'd12;
  localparam logic [4:0] S_DIVW    = 5'd13;
  localparam logic [4:0] S_LD_A    = 5'd14;
  localparam logic [4:0] S_LD_B    = 5'd15;
  localparam logic [4:0] S_LD_C    = 5'd16;
  localparam logic [4:0] S_ST_A    = 5'd17;
  localparam logic [4:0] S_ST_B    = 5'd18;
  localparam logic [4:0] S_PUSH    = 5'd19;
  localparam logic [4:0] S_PUSH_LO = 5'd20;
  localparam logic [4:0] S_DONE    = 5'd21;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] i;
  logic [1:0] i_next;
  logic [1:0] j;
  logic [1:0] j_next;

  logic [4:0] op5;
  logic       wide;
  logic       ret;
  logic       pw_pop;
  logic [1:0] npop;
  logic [1:0] npush;
  logic       psw;
  logic       poth;
  logic [7:0] tp;
  logic [7:0] cur_p;

  assign op5   = sts.ir[4:0];
  assign wide  = sts.ir[BIT_SHORT];
  assign ret   = sts.ir[BIT_RET];
  assign pw_pop = pop_wide(op5, i, wide);
  assign npop  = pop_count(op5);
  assign npush = push_count(op5);
  assign psw   = push_wide(op5, wide);
  assign poth  = push_other(op5);
  assign tp    = (ret ^ poth) ? sts.rsp : sts.dsp;
  assign cur_p = ret ? sts.rsp : sts.dsp;
  assign ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    i_next     = i;
    j_next     = j;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.item_op == IOP_EXEC) begin
          state_next = sts.running ? S_FETCH : S_DONE;
        end else begin
          cmd.host_wr = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_FETCH: begin
        cmd.rd_pc  = 1'b1;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        i_next = 2'd0;
        j_next = 2'd0;
        if (sts.ir == 8'd0) begin
          cmd.halt   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.prep   = 1'b1;
          state_next = (op5 == OP_LIT) ? S_LIT : S_POP;
        end
      end
      S_LIT: begin
        cmd.rd_pc  = 1'b1;
        state_next = S_LIT_P;
      end
      S_LIT_P: begin
        if (cur_p > PUSH_LIMIT1) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_OVER;
          state_next     = S_DONE;
        end else begin
          cmd.lit_push = 1'b1;
          if (wide && j == 2'd0) begin
            j_next     = 2'd1;
            state_next = S_LIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_POP: begin
        if (sts.k < (pw_pop ? 8'd2 : 8'd1)) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_UNDER;
          state_next     = S_DONE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP_B0;
        end
      end
      S_POP_B0: begin
        cmd.pop_cap_lo = 1'b1;
        cmd.slot       = i;
        if (pw_pop) begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP_B1;
        end else begin
          state_next = S_POP_END;
        end
      end
      S_POP_B1: begin
        cmd.pop_cap_hi = 1'b1;
        cmd.slot       = i;
        state_next     = S_POP_END;
      end
      S_POP_END: begin
        cmd.pop_commit = 1'b1;
        if (i == npop - 2'd1) begin
          i_next     = 2'd0;
          state_next = S_EXEC;
        end else begin
          i_next     = i + 2'd1;
          state_next = S_POP;
        end
      end
      S_EXEC: begin
        case (op5) inside
          OP_DIV: begin
            if (sts.r0_zero) begin
              cmd.fault      = 1'b1;
              cmd.fault_code = ST_DIVZ;
              state_next     = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIVW;
            end
          end
          OP_JMP: begin
            cmd.jump   = 1'b1;
            state_next = S_DONE;
          end
          OP_JCN: begin
            cmd.jump   = sts.r1_flag;
            state_next = S_DONE;
          end
          OP_POP: state_next = S_DONE;
          OP_LDZ, OP_LDR, OP_LDA: begin
            cmd.ea_load = 1'b1;
            state_next  = S_LD_A;
          end
          OP_DEI: state_next = S_LD_A;
          OP_STZ, OP_STR, OP_STA: begin
            cmd.ea_load = 1'b1;
            state_next  = S_ST_A;
          end
          OP_DEO: state_next = S_ST_A;
          default: begin
            cmd.alu    = 1'b1;
            state_next = S_PUSH;
          end
        endcase
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = S_PUSH;
        end
      end
      S_LD_A: begin
        cmd.rd_dev = (op5 == OP_DEI);
        state_next = S_LD_B;
      end
      S_LD_B: begin
        cmd.rd_dev = (op5 == OP_DEI);
        if (wide) begin
          cmd.cap    = CAP_HI;
          cmd.second = 1'b1;
          state_next = S_LD_C;
        end else begin
          cmd.cap    = CAP_BYTE;
          state_next = S_PUSH;
        end
      end
      S_LD_C: begin
        cmd.rd_dev = (op5 == OP_DEI);
        cmd.cap    = CAP_LO;
        state_next = S_PUSH;
      end
      S_ST_A: begin
        cmd.wr_hi = wide;
        if (op5 == OP_DEO) begin
          cmd.dev_wr = 1'b1;
          cmd.report = 1'b1;
        end else begin
          cmd.mem_wr = 1'b1;
        end
        state_next = wide ? S_ST_B : S_DONE;
      end
      S_ST_B: begin
        cmd.second = 1'b1;
        if (op5 == OP_DEO) begin
          cmd.dev_wr = 1'b1;
        end else begin
          cmd.mem_wr = 1'b1;
        end
        state_next = S_DONE;
      end
      S_PUSH, S_PUSH_LO: begin
        cmd.push_src   = push_src(op5, j);
        cmd.push_other = poth;
        if (state == S_PUSH && tp > (psw ? PUSH_LIMIT2 : PUSH_LIMIT1)) begin
          cmd.fault      = 1'b1;
          cmd.fault_code = ST_OVER;
          state_next     = S_DONE;
        end else begin
          cmd.push_wr = 1'b1;
          cmd.push_hi = (state == S_PUSH) && psw;
          if (state == S_PUSH && psw) begin
            state_next = S_PUSH_LO;
          end else if (j == npush - 2'd1) begin
            j_next     = 2'd0;
            cmd.jump   = (op5 == OP_JSR);
            state_next = S_DONE;
          end else begin
            j_next     = j + 2'd1;
            state_next = S_PUSH;
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stack_machine_cpu_core.sv =====
// Top level of the 8-bit stack machine core.
// Depends on smc_pkg, smc_ctrl and smc_datapath (which holds smc_div).
//
// Usage: the host sends items on the item channel (item_valid, item_stall,
// item). Each beat loads a memory byte, writes a device page byte, starts
// the machine at a vector, or executes one instruction. Every item gives
// exactly one beat on the result channel (result_valid, result_stall,
// result) with the status, the program counter and any device output.
// The core works on one item at a time. An instruction is fetched and
// decoded, pops its operands one byte at a time, executes, then loads or
// stores where the opcode asks and pushes any results one byte at a time;
// a literal skips the pop and execute steps, a zero byte halts, and a
// divide waits for the bit-serial divider. The result beat appears in the
// same cycle in which the next item can be taken.
// After reset the core sweeps main memory and the device page to zero, one
// address a cycle, and holds item_stall high meanwhile.
// The machine comes out of reset halted with the program counter at zero.
// The result sits in an output register; while the receiver stalls it
// holds its beat, and the core may accept the next item meanwhile but does
// not present its result until the register frees.
`default_nettype none

module stack_machine_cpu_core
  import smc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  cmd_t cmd;
  sts_t sts;
  logic ready;

  smc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .sts        (sts),
    .cmd        (cmd),
    .ready      (ready)
  );

  smc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .result_stall (result_stall),
    .sts          (sts),
    .result_valid (result_valid),
    .result       (result)
  );

  assign item_stall = !ready;

  // An accepted beat makes the core busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("core took two items back to back");

  // Port fields are zero whenever no device output was made.
  a_port_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.port_write_valid |->
      result.port_number == 8'd0 && result.port_value == 16'd0 && !result.port_wide)
    else $error("stale device output fields");

  // A divide is only started with a nonzero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.r0_zero)
    else $error("divide started with zero divisor");

  // Stack reads and writes never share a cycle.
  a_stack_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pop_rd && (cmd.push_wr || cmd.lit_push)))
    else $error("stack pop and push in one cycle");

endmodule

`default_nettype wire

// ===== tb/sv/tb_stack_machine_cpu_core.sv =====
// Self-checking testbench for the stack machine core: directed programs and
// random short programs, checked beat by beat against an in-bench machine.
// Depends on smc_pkg and stack_machine_cpu_core.
`default_nettype none

module tb_stack_machine_cpu_core;
  import smc_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  stack_machine_cpu_core uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #1 clk = ~clk;

  // Pending beats for the driver and the results the machine must produce.
  item_t   item_q[$];
  result_t result_q[$];
  int      items_total;
  int      items_sent;
  int      errors;
  int      quiet_cycles;
  logic    took_item = 1'b0;

  // Shadow machine state.
  logic [7:0]  mem_img[65536];
  logic [7:0]  dev_img[256];
  logic [7:0]  dstk[256];
  logic [7:0]  rstk[256];
  bit          dstk_set[256];
  bit          rstk_set[256];
  logic [7:0]  dptr, rptr;
  logic [15:0] pc_q;
  logic [2:0]  stat_q;

  // Per-instruction working state.
  bit          sel_r, keep_m, wide_m;
  logic [7:0]  kptr;
  logic [2:0]  flt;

  function automatic logic [7:0] stk_ptr(bit r);
    return r ? rptr : dptr;
  endfunction

  function automatic void set_ptr(bit r, logic [7:0] v);
    if (r) rptr = v;
    else dptr = v;
  endfunction

  function automatic logic [7:0] pop8();
    logic [7:0] v;
    if (flt != ST_RUN) return 8'h00;
    if (kptr == 0) begin
      flt = ST_UNDER;
      return 8'h00;
    end
    kptr = kptr - 8'd1;
    v = sel_r ? rstk[kptr] : dstk[kptr];
    if (!keep_m) set_ptr(sel_r, kptr);
    return v;
  endfunction

  function automatic logic [15:0] pop16();
    logic [7:0] lo, hi;
    if (flt != ST_RUN) return 16'h0000;
    if (kptr < 2) begin
      flt = ST_UNDER;
      return 16'h0000;
    end
    kptr = kptr - 8'd1;
    lo = sel_r ? rstk[kptr] : dstk[kptr];
    kptr = kptr - 8'd1;
    hi = sel_r ? rstk[kptr] : dstk[kptr];
    if (!keep_m) set_ptr(sel_r, kptr);
    return {hi, lo};
  endfunction

  function automatic logic [15:0] popm();
    return wide_m ? pop16() : {8'h00, pop8()};
  endfunction

  function automatic void push_to(bit r, bit two, logic [15:0] v);
    logic [7:0] p;
    if (flt != ST_RUN) return;
    p = stk_ptr(r);
    if (p > (two ? PUSH_LIMIT2 : PUSH_LIMIT1)) begin
      flt = ST_OVER;
      return;
    end
    if (two) begin
      if (r) begin rstk[p] = v[15:8]; rstk_set[p] = 1; end
      else begin dstk[p] = v[15:8]; dstk_set[p] = 1; end
      p = p + 8'd1;
    end
    if (r) begin rstk[p] = v[7:0]; rstk_set[p] = 1; end
    else begin dstk[p] = v[7:0]; dstk_set[p] = 1; end
    set_ptr(r, p + 8'd1);
  endfunction

  function automatic logic [15:0] rel_addr(logic [15:0] x);
    return pc_q + {{8{x[7]}}, x[7:0]};
  endfunction

  function automatic void jump_to(logic [15:0] x);
    if (flt != ST_RUN) return;
    pc_q = wide_m ? x : rel_addr(x);
  endfunction

  function automatic logic [15:0] peek(logic [15:0] a);
    if (wide_m) return {mem_img[a], mem_img[a + 16'd1]};
    return {8'h00, mem_img[a]};
  endfunction

  function automatic void poke(logic [15:0] a, logic [15:0] v);
    if (flt != ST_RUN) return;
    if (wide_m) begin
      mem_img[a] = v[15:8];
      mem_img[a + 16'd1] = v[7:0];
    end else begin
      mem_img[a] = v[7:0];
    end
  endfunction

  function automatic logic [7:0] dev_read(logic [7:0] p);
    if (p == PORT_DSP) return dptr;
    if (p == PORT_RSP) return rptr;
    return dev_img[p];
  endfunction

  // Port writes to the system page also move the matching stack pointer.
  function automatic void dev_write(logic [7:0] p, logic [7:0] v);
    dev_img[p] = v;
    if (p == PORT_DSP) dptr = v;
    else if (p == PORT_RSP) rptr = v;
  endfunction

  function automatic logic [7:0] port_after(logic [7:0] p);
    return {p[7:4], p[3:0] + 4'd1};
  endfunction

  // One instruction at pc_q; fills the port fields of res on a device output.
  function automatic void run_instr(inout result_t res);
    logic [7:0]  ins, p0;
    logic [15:0] x, y, c;
    logic [31:0] r;
    ins = mem_img[pc_q];
    pc_q = pc_q + 16'd1;
    if (ins == 8'h00) begin
      stat_q = ST_HALT;
      return;
    end
    wide_m = ins[BIT_SHORT];
    keep_m = ins[BIT_KEEP];
    sel_r = ins[BIT_RET];
    kptr = stk_ptr(sel_r);
    flt = ST_RUN;
    case (ins[4:0])
      OP_LIT: begin
        push_to(sel_r, 1'b0, {8'h00, mem_img[pc_q]});
        if (flt == ST_RUN) pc_q = pc_q + 16'd1;
        if (wide_m) begin
          push_to(sel_r, 1'b0, {8'h00, mem_img[pc_q]});
          if (flt == ST_RUN) pc_q = pc_q + 16'd1;
        end
      end
      OP_INC: begin x = popm(); push_to(sel_r, wide_m, x + 16'd1); end
      OP_POP: x = popm();
      OP_NIP: begin x = popm(); y = popm(); push_to(sel_r, wide_m, x); end
      OP_SWP: begin
        x = popm(); y = popm();
        push_to(sel_r, wide_m, x); push_to(sel_r, wide_m, y);
      end
      OP_ROT: begin
        c = popm(); y = popm(); x = popm();
        push_to(sel_r, wide_m, y); push_to(sel_r, wide_m, c); push_to(sel_r, wide_m, x);
      end
      OP_DUP: begin x = popm(); push_to(sel_r, wide_m, x); push_to(sel_r, wide_m, x); end
      OP_OVR: begin
        x = popm(); y = popm();
        push_to(sel_r, wide_m, y); push_to(sel_r, wide_m, x); push_to(sel_r, wide_m, y);
      end
      OP_EQU: begin x = popm(); y = popm(); push_to(sel_r, 1'b0, {15'd0, y == x}); end
      OP_NEQ: begin x = popm(); y = popm(); push_to(sel_r, 1'b0, {15'd0, y != x}); end
      OP_GTH: begin x = popm(); y = popm(); push_to(sel_r, 1'b0, {15'd0, y > x}); end
      OP_LTH: begin x = popm(); y = popm(); push_to(sel_r, 1'b0, {15'd0, y < x}); end
      OP_JMP: begin x = popm(); jump_to(x); end
      OP_JCN: begin x = popm(); y = {8'h00, pop8()}; if (y != 0) jump_to(x); end
      OP_JSR: begin x = popm(); push_to(!sel_r, 1'b1, pc_q); jump_to(x); end
      OP_STH: begin x = popm(); push_to(!sel_r, wide_m, x); end
      OP_LDZ: begin
        x = {8'h00, pop8()};
        if (flt == ST_RUN) push_to(sel_r, wide_m, peek(x));
      end
      OP_STZ: begin x = {8'h00, pop8()}; y = popm(); poke(x, y); end
      OP_LDR: begin
        x = {8'h00, pop8()};
        if (flt == ST_RUN) push_to(sel_r, wide_m, peek(rel_addr(x)));
      end
      OP_STR: begin x = {8'h00, pop8()}; y = popm(); poke(rel_addr(x), y); end
      OP_LDA: begin x = pop16(); if (flt == ST_RUN) push_to(sel_r, wide_m, peek(x)); end
      OP_STA: begin x = pop16(); y = popm(); poke(x, y); end
      OP_DEI: begin
        x = {8'h00, pop8()};
        if (flt == ST_RUN) begin
          y = {8'h00, dev_read(x[7:0])};
          if (wide_m) y = {y[7:0], dev_read(port_after(x[7:0]))};
          push_to(sel_r, wide_m, y);
        end
      end
      OP_DEO: begin
        x = {8'h00, pop8()}; y = popm();
        if (flt == ST_RUN) begin
          p0 = x[7:0];
          if (wide_m) begin
            // Both bytes land in the page before either pointer alias moves.
            dev_img[p0] = y[15:8];
            dev_img[port_after(p0)] = y[7:0];
            dev_write(p0, dev_img[p0]);
            dev_write(port_after(p0), dev_img[port_after(p0)]);
          end else begin
            dev_write(p0, y[7:0]);
          end
          res.port_write_valid = 1'b1;
          res.port_number = p0;
          res.port_value = wide_m ? y : {8'h00, y[7:0]};
          res.port_wide = wide_m;
        end
      end
      OP_ADD: begin x = popm(); y = popm(); push_to(sel_r, wide_m, y + x); end
      OP_SUB: begin x = popm(); y = popm(); push_to(sel_r, wide_m, y - x); end
      OP_MUL: begin x = popm(); y = popm(); push_to(sel_r, wide_m, y * x); end
      OP_DIV: begin
        x = popm(); y = popm();
        if (flt == ST_RUN) begin
          if (x == 0) flt = ST_DIVZ;
          else push_to(sel_r, wide_m, y / x);
        end
      end
      OP_AND: begin x = popm(); y = popm(); push_to(sel_r, wide_m, y & x); end
      OP_ORA: begin x = popm(); y = popm(); push_to(sel_r, wide_m, y | x); end
      OP_EOR: begin x = popm(); y = popm(); push_to(sel_r, wide_m, y ^ x); end
      default: begin
        x = {8'h00, pop8()}; y = popm();
        r = ({16'h0000, y} >> x[3:0]) << x[7:4];
        push_to(sel_r, wide_m, r[15:0]);
      end
    endcase
    if (flt != ST_RUN) stat_q = flt;
  endfunction

  function automatic result_t machine_step(item_t it);
    result_t res;
    res = '0;
    case (it.operation)
      IOP_MEM: mem_img[it.address] = it.data;
      IOP_DEV: dev_img[it.address[7:0]] = it.data;
      IOP_START: begin
        pc_q = it.address;
        stat_q = (it.address == 0) ? ST_HALT : ST_RUN;
      end
      default: if (stat_q == ST_RUN) run_instr(res);
    endcase
    res.status = stat_q;
    res.program_counter = pc_q;
    return res;
  endfunction

  // An instruction that pops must find every byte it could read already
  // written; the stack contents are undefined until then.
  function automatic bit pops_are_defined();
    logic [7:0] ins, p;
    bit r;
    if (stat_q != ST_RUN) return 1;
    ins = mem_img[pc_q];
    if (ins == 8'h00 || ins[4:0] == OP_LIT) return 1;
    r = ins[BIT_RET];
    p = stk_ptr(r);
    for (int i = 1; i <= 6; i++) begin
      if (p >= i && !(r ? rstk_set[p - 8'(i)] : dstk_set[p - 8'(i)])) return 0;
    end
    return 1;
  endfunction

  task automatic queue_beat(logic [1:0] op, logic [15:0] addr, logic [7:0] dat);
    item_t it;
    it.operation = op;
    it.address = addr;
    it.data = dat;
    item_q.push_back(it);
    result_q.push_back(machine_step(it));
  endtask

  task automatic load_bytes(logic [15:0] base, logic [7:0] bytes[$]);
    foreach (bytes[i]) queue_beat(IOP_MEM, base + 16'(i), bytes[i]);
  endtask

  // Execute up to n instructions, leaving early once a pop could reach
  // an undefined stack byte.
  task automatic run_steps(int n);
    for (int i = 0; i < n; i++) begin
      if (!pops_are_defined()) return;
      queue_beat(IOP_EXEC, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_program();
    logic [15:0] base;
    logic [7:0]  prog[$];
    int          len;
    case ($urandom_range(0, 9))
      0: base = 16'hFFF8 + 16'($urandom_range(0, 7));
      1: base = 16'($urandom);
      default: base = 16'h0100 + 16'($urandom_range(0, 16'h0EFF));
    endcase
    len = $urandom_range(3, 14);
    prog = {};
    while (prog.size() < len) begin
      if ($urandom_range(0, 99) < 40) begin
        // A literal with random flags, then its one or two bytes.
        prog.push_back({3'($urandom_range(1, 7)), 5'b00000});
        prog.push_back(8'($urandom));
        if (prog[prog.size() - 2][BIT_SHORT]) prog.push_back(8'($urandom));
      end else begin
        prog.push_back(8'($urandom));
      end
    end
    load_bytes(base, prog);
    if ($urandom_range(0, 4) == 0) queue_beat(IOP_DEV, 16'($urandom), 8'($urandom));
    queue_beat(IOP_START, base, 8'($urandom));
    run_steps(len + 4);
  endtask

  // Stimulus: a directed set of corner cases, then random host beats and random programs.
  initial begin
    logic [7:0] prog[$];
    logic [1:0] rop;
    foreach (mem_img[i]) mem_img[i] = 8'h00;
    foreach (dev_img[i]) dev_img[i] = 8'h00;
    dptr = 0;
    rptr = 0;
    pc_q = 0;
    stat_q = ST_HALT;
    errors = 0;

    // Extremes of the host operations and an execute while halted.
    queue_beat(IOP_MEM, 16'hFFFF, 8'hFF);
    queue_beat(IOP_DEV, 16'hFFFF, 8'hAA);
    queue_beat(IOP_EXEC, 16'h0000, 8'h00);
    queue_beat(IOP_START, 16'h0000, 8'hFF);
    // Divide by zero: push 5 and 0, then divide.
    prog = {8'h80, 8'h05, 8'h80, 8'h00, {3'b000, OP_DIV}};
    load_bytes(16'h0100, prog);
    queue_beat(IOP_START, 16'h0100, 8'h00);
    run_steps(3);
    // Underflow: a pop on the emptied data stack.
    queue_beat(IOP_MEM, 16'h0110, {3'b000, OP_POP});
    queue_beat(IOP_START, 16'h0110, 8'h00);
    run_steps(1);
    // Overflow: move the data stack pointer to the top through the system
    // port, then push once more.
    prog = {8'h80, 8'hFF, 8'h80, PORT_DSP, {3'b000, OP_DEO}, 8'h80, 8'h01};
    load_bytes(16'h0120, prog);
    queue_beat(IOP_START, 16'h0120, 8'h00);
    run_steps(4);

    while (item_q.size() < 1350) begin
      case ($urandom_range(0, 9))
        0: queue_beat(IOP_MEM, 16'($urandom), 8'($urandom));
        1: queue_beat(IOP_DEV, 16'($urandom), 8'($urandom));
        2: begin
          // A random host operation; an execute still has to find its
          // stack bytes written.
          rop = 2'($urandom_range(0, 3));
          if (rop == IOP_EXEC) run_steps(1);
          else queue_beat(rop, 16'($urandom), 8'($urandom));
        end
        default: random_program();
      endcase
    end
    // Restore sane stack pointers is not needed; the run just ends here.
    items_total = item_q.size();
    items_sent = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || item_valid || result_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("stack_machine_cpu_core: match");
    else $display("stack_machine_cpu_core: mismatch");
    $finish;
  end

  // Idle rates follow the three phases of the run.
  function automatic int sender_idle();
    if (items_sent < items_total / 3) return 24;
    if (items_sent < 2 * items_total / 3) return 58;
    return 0;
  endfunction

  function automatic int receiver_idle();
    if (items_sent < items_total / 3) return 58;
    if (items_sent < 2 * items_total / 3) return 24;
    return 0;
  endfunction

  // Driver: a beat stays put until it is accepted; a new one is offered
  // only after that, or after an idle cycle.
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_valid || took_item) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= sender_idle()) begin
          item <= item_q.pop_front();
          item_valid <= 1'b1;
          items_sent <= items_sent + 1;
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(0, 99) < receiver_idle());
    end
  end

  // Monitor: every result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    took_item <= item_valid && !item_stall;
    if (!rst && result_valid && !result_stall) begin
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected: %h", result);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.program_counter !== want.program_counter) begin
          $error("program_counter: expected %h, got %h", want.program_counter,
                 result.program_counter);
          errors++;
        end
        if (result.port_write_valid !== want.port_write_valid) begin
          $error("port_write_valid: expected %0d, got %0d", want.port_write_valid,
                 result.port_write_valid);
          errors++;
        end
        if (result.port_number !== want.port_number) begin
          $error("port_number: expected %h, got %h", want.port_number, result.port_number);
          errors++;
        end
        if (result.port_value !== want.port_value) begin
          $error("port_value: expected %h, got %h", want.port_value, result.port_value);
          errors++;
        end
        if (result.port_wide !== want.port_wide) begin
          $error("port_wide: expected %0d, got %0d", want.port_wide, result.port_wide);
          errors++;
        end
      end
    end
  end

  // Watchdog: the limit covers the memory sweep after reset plus margin.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stack_machine_cpu_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule

`default_nettype wire
